// File: rtl/interrupt_vector_handler_table_macros.svh
// assertion helpers shared by the rtl files
`ifndef INTERRUPT_VECTOR_HANDLER_TABLE_MACROS_SVH
`define INTERRUPT_VECTOR_HANDLER_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IVHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ivht assertion failed");

// next-cycle implication
`define IVHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ivht assertion failed");

// invariant
`define IVHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ivht assertion failed");

`else

`define IVHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IVHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define IVHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

// File: rtl/ivht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ivht_pkg;

    localparam int IVHT_SLOTS_DEF = 20;

    // command codes
    localparam logic [1:0] CMD_REG  = 2'd0;
    localparam logic [1:0] CMD_REM  = 2'd1;
    localparam logic [1:0] CMD_LOOK = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ILLEGAL  = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FAULT    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    // internal source numbering
    localparam logic [7:0] SRC_BASE   = 8'd64;
    localparam logic [7:0] SRC_MAX    = 8'd62;
    localparam logic [7:0] SRC_RO_MAX = 8'd8;
    localparam int         SRC_COUNT  = 63;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [7:0]  vec;
        logic [15:0] hid;
        logic [31:0] dev;
        logic [31:0] arg;
    } t_entry;

    typedef struct packed {
        logic   we;
        logic   clr;
        t_entry entry;
    } t_tbl_wr;

    typedef struct packed {
        logic       unmask;
        logic       wr_ctl;
        logic [5:0] idx;
        logic [5:0] pl;
    } t_src_upd;

endpackage

`default_nettype wire

// File: rtl/ivht_table.sv
`timescale 1ns / 1ps
`default_nettype none

module ivht_table #(
    parameter int TABLE_SLOTS = ivht_pkg::IVHT_SLOTS_DEF,
    parameter int SLOT_W      = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    output ivht_pkg::t_entry       o_rd_entry,
    input  wire logic [SLOT_W-1:0] i_wr_addr,
    input  wire ivht_pkg::t_tbl_wr i_wr
);
    import ivht_pkg::*;

    t_entry                 r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    t_entry                 r_rd_entry;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr_addr] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    // per-slot valid bits, an invalid slot reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_wr.clr) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_valid ? r_rd_entry : '0;

endmodule

`default_nettype wire

// File: rtl/ivht_src.sv
`timescale 1ns / 1ps
`default_nettype none

`include "interrupt_vector_handler_table_macros.svh"

module ivht_src (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ivht_pkg::t_src_upd i_upd
);
    import ivht_pkg::*;

    logic [SRC_COUNT-1:0] r_mask;
    logic [SRC_COUNT-1:0] r_ctl_valid;
    logic [5:0]           r_ctl [SRC_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '1;
            r_ctl_valid <= '0;
        end else begin
            if (i_upd.unmask) begin
                r_mask[i_upd.idx] <= 1'b0;
            end
            if (i_upd.wr_ctl) begin
                r_ctl_valid[i_upd.idx] <= 1'b1;
            end
        end
    end

    // level and priority per source
    always_ff @(posedge i_clk) begin
        if (i_upd.wr_ctl) begin
            r_ctl[i_upd.idx] <= i_upd.pl;
        end
    end

    `IVHT_ASSERT_NEXT(a_unmask_sticks, i_clk, i_rst_n, i_upd.unmask, !r_mask[$past(i_upd.idx)])
    `IVHT_ASSERT_NEXT(a_ctl_written, i_clk, i_rst_n, i_upd.wr_ctl, r_ctl_valid[$past(i_upd.idx)] && (r_ctl[$past(i_upd.idx)] == $past(i_upd.pl)))
    `IVHT_ASSERT_ALWAYS(a_src0_masked, i_clk, i_rst_n, r_mask[0])

endmodule

`default_nettype wire

// File: rtl/ivht_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "interrupt_vector_handler_table_macros.svh"

module ivht_seq #(
    parameter int TABLE_SLOTS = ivht_pkg::IVHT_SLOTS_DEF,
    parameter int SLOT_W      = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_vector,
    input  wire logic [15:0]       i_handler_id,
    input  wire logic [31:0]       i_dev_tag,
    input  wire logic [31:0]       i_arg_tag,
    input  wire logic [2:0]        i_level,
    input  wire logic [2:0]        i_priority_req,
    output logic                   o_done,
    output logic [2:0]             o_status,
    output logic [4:0]             o_slot,
    output logic [15:0]            o_found_handler,
    output logic [31:0]            o_found_dev,
    output logic [31:0]            o_found_arg,
    output logic [SLOT_W-1:0]      o_rd_addr,
    input  wire ivht_pkg::t_entry  i_rd_entry,
    output logic [SLOT_W-1:0]      o_wr_addr,
    output ivht_pkg::t_tbl_wr      o_wr,
    output ivht_pkg::t_src_upd     o_upd
);
    import ivht_pkg::*;

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TABLE_SLOTS - 1);

    t_state            r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [7:0]        r_vec, n_vec;
    logic [15:0]       r_hid, n_hid;
    logic [31:0]       r_dev, n_dev;
    logic [31:0]       r_arg, n_arg;
    logic [5:0]        r_pl, n_pl;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_done, n_done;
    logic [2:0]        r_status, n_status;
    logic [4:0]        r_slot, n_slot;
    logic [15:0]       r_fh, n_fh;
    logic [31:0]       r_fd, n_fd;
    logic [31:0]       r_fa, n_fa;

    logic [7:0]        src_off;
    logic              src_ok;

    assign src_off = r_vec - SRC_BASE;
    assign src_ok  = (src_off != 8'd0) && (src_off <= SRC_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_vec    <= n_vec;
        r_hid    <= n_hid;
        r_dev    <= n_dev;
        r_arg    <= n_arg;
        r_pl     <= n_pl;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_fh     <= n_fh;
        r_fd     <= n_fd;
        r_fa     <= n_fa;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_vec    = r_vec;
        n_hid    = r_hid;
        n_dev    = r_dev;
        n_arg    = r_arg;
        n_pl     = r_pl;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_status = r_status;
        n_slot   = r_slot;
        n_fh     = r_fh;
        n_fd     = r_fd;
        n_fa     = r_fa;

        o_rd_addr       = '0;
        o_wr_addr       = r_idx;
        o_wr.we         = 1'b0;
        o_wr.clr        = 1'b0;
        o_wr.entry.vec  = r_vec;
        o_wr.entry.hid  = r_hid;
        o_wr.entry.dev  = r_dev;
        o_wr.entry.arg  = r_arg;
        o_upd.unmask    = 1'b0;
        o_upd.wr_ctl    = 1'b0;
        o_upd.idx       = src_off[5:0];
        o_upd.pl        = r_pl;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd  = i_cmd;
                    n_vec  = i_vector;
                    n_hid  = i_handler_id;
                    n_dev  = i_dev_tag;
                    n_arg  = i_arg_tag;
                    n_pl   = {i_level, i_priority_req};
                    n_idx  = '0;
                    n_slot = '0;
                    n_fh   = '0;
                    n_fd   = '0;
                    n_fa   = '0;
                    n_done = 1'b1;
                    case (i_cmd)
                        CMD_REG: begin
                            if (i_vector == 8'd0 || i_handler_id == 16'd0) begin
                                n_status = ST_ILLEGAL;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_REM: begin
                            if (i_handler_id == 16'd0) begin
                                n_status = ST_ILLEGAL;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_LOOK: begin
                            if (i_vector == 8'd0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_ILLEGAL;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // slot r_idx is on the read port, prefetch the next one
                if (r_idx != LAST) begin
                    o_rd_addr = r_idx + 1'b1;
                end
                n_slot = 5'(r_idx);
                n_done = 1'b1;
                n_state = S_IDLE;
                if (r_cmd == CMD_REG && i_rd_entry.vec == r_vec) begin
                    n_status = ST_DUP;
                end else if (r_cmd == CMD_REG && i_rd_entry.vec == 8'd0) begin
                    o_wr.we = 1'b1;
                    n_status = ST_OK;
                    if (r_vec >= SRC_BASE) begin
                        if (src_ok) begin
                            o_upd.unmask = 1'b1;
                            o_upd.wr_ctl = (src_off > SRC_RO_MAX);
                        end else begin
                            n_status = ST_FAULT;
                        end
                    end
                end else if (r_cmd == CMD_REM && i_rd_entry.hid == r_hid) begin
                    o_wr.clr = 1'b1;
                    n_status = ST_OK;
                end else if (r_cmd == CMD_LOOK && i_rd_entry.vec == r_vec) begin
                    n_status = ST_OK;
                    n_fh     = i_rd_entry.hid;
                    n_fd     = i_rd_entry.dev;
                    n_fa     = i_rd_entry.arg;
                end else if (r_idx == LAST) begin
                    n_slot   = '0;
                    n_status = (r_cmd == CMD_REG) ? ST_FULL : ST_NOTFOUND;
                end else begin
                    n_done  = 1'b0;
                    n_state = S_SCAN;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_found_handler = r_fh;
    assign o_found_dev     = r_fd;
    assign o_found_arg     = r_fa;

    `IVHT_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `IVHT_ASSERT_NEXT(a_scan_ends_done, i_clk, i_rst_n, r_state == S_SCAN, (r_state == S_SCAN) || r_done)
    `IVHT_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, (r_state == S_IDLE) && i_start, (r_state == S_SCAN) || r_done)

endmodule

`default_nettype wire

// File: rtl/interrupt_vector_handler_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+----------------------------------------
// command   | in        | start high, busy low        | i_cmd i_vector i_handler_id i_dev_tag
//           |           |                             | i_arg_tag i_level i_priority_req
// result    | out       | o_done, one cycle per beat  | o_status o_slot o_found_handler
//           |           |                             | o_found_dev o_found_arg
//
// a command that needs the table scans from slot 0 up to the last slot at most, one slot
// per cycle through the single table read port, and its result strobes the cycle after
// commands rejected on their fields alone answer the cycle after they are taken
// busy is high only while scanning, so a new command can be taken during the strobe
// reset (synchronous, active low) empties every slot and masks every source at once
// results cannot be held off, each beat is valid for exactly one cycle

module interrupt_vector_handler_table #(
    parameter int TABLE_SLOTS = ivht_pkg::IVHT_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_vector,
    input  wire logic [15:0] i_handler_id,
    input  wire logic [31:0] i_dev_tag,
    input  wire logic [31:0] i_arg_tag,
    input  wire logic [2:0]  i_level,
    input  wire logic [2:0]  i_priority_req,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [4:0]       o_slot,
    output logic [15:0]      o_found_handler,
    output logic [31:0]      o_found_dev,
    output logic [31:0]      o_found_arg
);
    import ivht_pkg::*;

    // slot index width, at least one bit for a single-slot table
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // table read and write side
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    t_entry            rd_entry;
    t_tbl_wr           tbl_wr;

    // source mask and control update
    t_src_upd          src_upd;

    // sequencer: latches the command, walks the slots and compares each one
    ivht_seq #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_cmd           (i_cmd),
        .i_vector        (i_vector),
        .i_handler_id    (i_handler_id),
        .i_dev_tag       (i_dev_tag),
        .i_arg_tag       (i_arg_tag),
        .i_level         (i_level),
        .i_priority_req  (i_priority_req),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_found_handler (o_found_handler),
        .o_found_dev     (o_found_dev),
        .o_found_arg     (o_found_arg),
        .o_rd_addr       (rd_addr),
        .i_rd_entry      (rd_entry),
        .o_wr_addr       (wr_addr),
        .o_wr            (tbl_wr),
        .o_upd           (src_upd)
    );

    // handler table: one write and one registered read per cycle, valid bit per slot
    ivht_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_addr  (wr_addr),
        .i_wr       (tbl_wr)
    );

    // internal source mask and level/priority store
    ivht_src u_src (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (src_upd)
    );

endmodule

`default_nettype wire

// File: sim/ivht_result_checker.sv
`timescale 1ns / 1ps

module ivht_result_checker #(
    parameter int TABLE_SLOTS = ivht_pkg::IVHT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_vector,
    input  logic [15:0] i_handler_id,
    input  logic [31:0] i_dev_tag,
    input  logic [31:0] i_arg_tag,
    input  logic [2:0]  i_level,
    input  logic [2:0]  i_priority_req,
    input  logic        i_done,
    input  logic [2:0]  i_status,
    input  logic [4:0]  i_slot,
    input  logic [15:0] i_found_handler,
    input  logic [31:0] i_found_dev,
    input  logic [31:0] i_found_arg,
    output int          o_errors,
    output int          o_pending
);

    import ivht_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] hid;
        logic [31:0] dev;
        logic [31:0] arg;
    } t_answer;

    // shadow of the handler table and the source control block
    logic [7:0]           tbl_vec [TABLE_SLOTS];
    logic [15:0]          tbl_hid [TABLE_SLOTS];
    logic [31:0]          tbl_dev [TABLE_SLOTS];
    logic [31:0]          tbl_arg [TABLE_SLOTS];
    logic [SRC_COUNT-1:0] src_masked;
    logic [5:0]           src_ctl [SRC_COUNT];

    t_answer answers [$];
    int      mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic table_answer(
        input  logic [1:0]  c,
        input  logic [7:0]  v,
        input  logic [15:0] h,
        input  logic [31:0] d,
        input  logic [31:0] a,
        input  logic [2:0]  l,
        input  logic [2:0]  p,
        output t_answer     ans
    );
        logic [7:0] src;
        logic       hit;
        int         i;
        ans = '0;
        hit = 1'b0;
        case (c)
            CMD_REG: begin
                if (v == 8'd0 || h == 16'd0) begin
                    ans.status = ST_ILLEGAL;
                end else begin
                    // first slot holding the vector or empty decides
                    for (i = 0; i < TABLE_SLOTS && !hit; i++) begin
                        if (tbl_vec[i] == v) begin
                            hit        = 1'b1;
                            ans.status = ST_DUP;
                            ans.slot   = 5'(i);
                        end else if (tbl_vec[i] == 8'd0) begin
                            hit        = 1'b1;
                            tbl_vec[i] = v;
                            tbl_hid[i] = h;
                            tbl_dev[i] = d;
                            tbl_arg[i] = a;
                            ans.status = ST_OK;
                            ans.slot   = 5'(i);
                            if (v >= SRC_BASE) begin
                                src = v - SRC_BASE;
                                if (src == 8'd0 || src > SRC_MAX) begin
                                    ans.status = ST_FAULT;
                                end else begin
                                    src_masked[src] = 1'b0;
                                    if (src > SRC_RO_MAX) begin
                                        src_ctl[src] = {l, p};
                                    end
                                end
                            end
                        end
                    end
                    if (!hit) begin
                        ans.status = ST_FULL;
                    end
                end
            end
            CMD_REM: begin
                if (h == 16'd0) begin
                    ans.status = ST_ILLEGAL;
                end else begin
                    for (i = 0; i < TABLE_SLOTS && !hit; i++) begin
                        if (tbl_hid[i] == h) begin
                            hit        = 1'b1;
                            tbl_vec[i] = '0;
                            tbl_hid[i] = '0;
                            tbl_dev[i] = '0;
                            tbl_arg[i] = '0;
                            ans.slot   = 5'(i);
                        end
                    end
                    ans.status = hit ? ST_OK : ST_NOTFOUND;
                end
            end
            CMD_LOOK: begin
                // vector 0 never matches, empty slots hold it
                if (v != 8'd0) begin
                    for (i = 0; i < TABLE_SLOTS && !hit; i++) begin
                        if (tbl_vec[i] == v) begin
                            hit      = 1'b1;
                            ans.slot = 5'(i);
                            ans.hid  = tbl_hid[i];
                            ans.dev  = tbl_dev[i];
                            ans.arg  = tbl_arg[i];
                        end
                    end
                end
                ans.status = hit ? ST_OK : ST_NOTFOUND;
            end
            default: begin
                ans.status = ST_ILLEGAL;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s expected 0x%0h actual 0x%0h", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer ans;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                tbl_vec[i] = '0;
                tbl_hid[i] = '0;
                tbl_dev[i] = '0;
                tbl_arg[i] = '0;
            end
            for (int s = 0; s < SRC_COUNT; s++) begin
                src_ctl[s] = '0;
            end
            src_masked = '1;
            answers.delete();
        end else begin
            // result beat first, then the command taken at this edge
            if (i_done) begin
                if (answers.size() == 0) begin
                    $error("result beat with nothing expected, status %0d slot %0d",
                           i_status, i_slot);
                    mismatches++;
                end else begin
                    ans = answers.pop_front();
                    check_field("status", 32'(ans.status), 32'(i_status));
                    check_field("slot", 32'(ans.slot), 32'(i_slot));
                    check_field("found_handler", 32'(ans.hid), 32'(i_found_handler));
                    check_field("found_dev", ans.dev, i_found_dev);
                    check_field("found_arg", ans.arg, i_found_arg);
                end
            end
            if (i_start && !i_busy) begin
                table_answer(i_cmd, i_vector, i_handler_id, i_dev_tag, i_arg_tag,
                             i_level, i_priority_req, ans);
                answers.push_back(ans);
            end
        end
        o_errors  <= mismatches;
        o_pending <= answers.size();
    end

endmodule

// File: sim/tb_interrupt_vector_handler_table.sv
`timescale 1ns / 1ps

module tb_interrupt_vector_handler_table;

    import ivht_pkg::*;

    localparam int TABLE_SLOTS  = IVHT_SLOTS_DEF;
    localparam int RANDOM_BEATS = 1450;
    // slowest beat is a full scan plus the strobe plus the longest gap, many times over
    localparam int LIMIT_CYCLES = 400000;

    // the one command code the block does not define
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // mix of commands in a random phase
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    localparam int VEC_POOL = 24;
    localparam int HID_POOL = 10;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  cmd           = '0;
    logic [7:0]  vector        = '0;
    logic [15:0] handler_id    = '0;
    logic [31:0] dev_tag       = '0;
    logic [31:0] arg_tag       = '0;
    logic [2:0]  level         = '0;
    logic [2:0]  priority_req  = '0;
    logic        done;
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [15:0] found_handler;
    logic [31:0] found_dev;
    logic [31:0] found_arg;
    int          errors;
    int          pending;
    int          cycle_count   = 0;

    // random part bookkeeping
    logic [7:0]  vec_pool [VEC_POOL];
    logic [15:0] hid_pool [HID_POOL];
    logic [15:0] spare_hids [$];
    logic [1:0]  nx_cmd;
    logic [7:0]  nx_vec;
    logic [15:0] nx_hid;
    int          beats_sent;
    int          phase_kind;
    int          phase_len;
    int          reg_cut;
    int          rem_cut;
    int          pick;
    int          burst_left;
    bit          gaps_on;

    interrupt_vector_handler_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cmd),
        .i_vector       (vector),
        .i_handler_id   (handler_id),
        .i_dev_tag      (dev_tag),
        .i_arg_tag      (arg_tag),
        .i_level        (level),
        .i_priority_req (priority_req),
        .o_done         (done),
        .o_status       (status),
        .o_slot         (slot),
        .o_found_handler(found_handler),
        .o_found_dev    (found_dev),
        .o_found_arg    (found_arg)
    );

    // watches both channels, predicts every result and counts mismatches
    ivht_result_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) answer_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (cmd),
        .i_vector       (vector),
        .i_handler_id   (handler_id),
        .i_dev_tag      (dev_tag),
        .i_arg_tag      (arg_tag),
        .i_level        (level),
        .i_priority_req (priority_req),
        .i_done         (done),
        .i_status       (status),
        .i_slot         (slot),
        .i_found_handler(found_handler),
        .i_found_dev    (found_dev),
        .i_found_arg    (found_arg),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog, a hung handshake ends the run here
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("interrupt_vector_handler_table test failed");
        $finish;
    end

    // present one command beat and hold it until the block takes it
    // start stays high on return so back-to-back beats need no extra edge
    task automatic issue(
        input logic [1:0]  c,
        input logic [7:0]  v,
        input logic [15:0] h,
        input logic [31:0] d,
        input logic [31:0] a,
        input logic [2:0]  l,
        input logic [2:0]  p
    );
        start        <= 1'b1;
        cmd          <= c;
        vector       <= v;
        handler_id   <= h;
        dev_tag      <= d;
        arg_tag      <= a;
        level        <= l;
        priority_req <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin
        // synchronous reset, held low and then released
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed beats ----
        // lookup of vector 0 is never a hit
        issue(CMD_LOOK, 8'd0, 16'h0000, '0, '0, 3'd0, 3'd0);
        // register with vector 0 or handler 0 is illegal
        issue(CMD_REG, 8'd0, 16'h0101, 32'h1111_1111, 32'h2222_2222, 3'd1, 3'd1);
        issue(CMD_REG, 8'd16, 16'h0000, 32'h1111_1111, 32'h2222_2222, 3'd1, 3'd1);
        // remove by handler 0 is illegal, remove of an unknown handler misses
        issue(CMD_REM, 8'd0, 16'h0000, '0, '0, 3'd0, 3'd0);
        issue(CMD_REM, 8'd0, 16'h1234, '0, '0, 3'd0, 3'd0);
        // spare command code, every field at its top
        issue(CMD_SPARE, 8'hFF, 16'hFFFF, '1, '1, 3'd7, 3'd7);
        // source 0 is out of range: entry kept, fault reported
        issue(CMD_REG, 8'd64, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 3'd7);
        // sources 1 and 8 are read-only, 9 and 62 take a control word
        issue(CMD_REG, 8'd65, 16'h0001, 32'hA5A5_0001, 32'h5A5A_0001, 3'd7, 3'd7);
        issue(CMD_REG, 8'd72, 16'h0002, 32'hA5A5_0002, 32'h5A5A_0002, 3'd3, 3'd4);
        issue(CMD_REG, 8'd73, 16'h0003, 32'hA5A5_0003, 32'h5A5A_0003, 3'd7, 3'd0);
        issue(CMD_REG, 8'd126, 16'h0004, 32'hA5A5_0004, 32'h5A5A_0004, 3'd0, 3'd7);
        // sources above 62 fault, top vector included
        issue(CMD_REG, 8'd127, 16'h0005, 32'hA5A5_0005, 32'h5A5A_0005, 3'd2, 3'd2);
        issue(CMD_REG, 8'd255, 16'h8000, 32'h0000_0000, 32'hFFFF_FFFF, 3'd5, 3'd6);
        issue(CMD_REG, 8'd1, 16'h7FFF, 32'h8000_0000, 32'h0000_0001, 3'd0, 3'd0);
        // duplicate vector
        issue(CMD_REG, 8'd65, 16'h0006, 32'hDEAD_0006, 32'hBEEF_0006, 3'd1, 3'd1);
        // lookups, hit and miss
        issue(CMD_LOOK, 8'd65, 16'h0000, '0, '0, 3'd0, 3'd0);
        issue(CMD_LOOK, 8'd255, 16'h0000, '0, '0, 3'd0, 3'd0);
        issue(CMD_LOOK, 8'd200, 16'h0000, '0, '0, 3'd0, 3'd0);
        // free slot 0, then a re-register of 65 lands there since the
        // empty slot comes before the existing copy
        issue(CMD_REM, 8'd0, 16'hFFFF, '0, '0, 3'd0, 3'd0);
        issue(CMD_REG, 8'd65, 16'h0009, 32'hCAFE_0009, 32'hF00D_0009, 3'd4, 3'd4);
        issue(CMD_LOOK, 8'd65, 16'h0000, '0, '0, 3'd0, 3'd0);
        issue(CMD_REM, 8'd0, 16'h0001, '0, '0, 3'd0, 3'd0);

        // ---- random beats ----
        // a small fixed set of handler ids so removes find their entries
        hid_pool[0] = 16'h0001;
        hid_pool[1] = 16'hFFFF;
        hid_pool[2] = 16'h8000;
        hid_pool[3] = 16'h7FFF;
        for (int k = 4; k < HID_POOL; k++) begin
            hid_pool[k] = 16'($urandom_range(1, 65535));
        end

        beats_sent = 0;
        burst_left = $urandom_range(1, 20);
        while (beats_sent < RANDOM_BEATS) begin
            phase_kind = $urandom_range(PH_FILL, PH_MIXED);
            phase_len  = $urandom_range(40, 120);
            // about one phase in four runs without any gaps
            gaps_on    = ($urandom_range(0, 3) != 0);
            case (phase_kind)
                PH_FILL: begin
                    reg_cut = 80;
                    rem_cut = 85;
                end
                PH_DRAIN: begin
                    reg_cut = 20;
                    rem_cut = 70;
                end
                default: begin
                    reg_cut = 45;
                    rem_cut = 70;
                end
            endcase

            // fresh vector set per phase, a little larger than the table
            // so fill phases run it full; weighted toward source edges
            for (int k = 0; k < VEC_POOL; k++) begin
                case ($urandom_range(0, 4))
                    0: vec_pool[k] = 8'($urandom_range(1, 63));
                    1: vec_pool[k] = 8'($urandom_range(64, 126));
                    2: vec_pool[k] = 8'($urandom_range(127, 255));
                    3: vec_pool[k] = 8'($urandom_range(65, 90));
                    default: begin
                        case ($urandom_range(0, 5))
                            0: vec_pool[k] = 8'd64;
                            1: vec_pool[k] = 8'd72;
                            2: vec_pool[k] = 8'd73;
                            3: vec_pool[k] = 8'd126;
                            4: vec_pool[k] = 8'd127;
                            default: vec_pool[k] = 8'd255;
                        endcase
                    end
                endcase
            end

            for (int n = 0; n < phase_len && beats_sent < RANDOM_BEATS; n++) begin
                pick   = $urandom_range(0, 99);
                nx_vec = vec_pool[$urandom_range(0, VEC_POOL - 1)];
                nx_hid = hid_pool[$urandom_range(0, HID_POOL - 1)];
                if (pick < 5) begin
                    // noise: rejected or odd beats
                    case ($urandom_range(0, 5))
                        0: nx_cmd = CMD_SPARE;
                        1: begin
                            nx_cmd = CMD_REG;
                            nx_vec = 8'd0;
                        end
                        2: begin
                            nx_cmd = CMD_REG;
                            nx_hid = 16'd0;
                        end
                        3: begin
                            nx_cmd = CMD_REM;
                            nx_hid = 16'd0;
                        end
                        4: begin
                            nx_cmd = CMD_LOOK;
                            nx_vec = 8'd0;
                        end
                        default: begin
                            nx_cmd = 2'($urandom_range(0, 3));
                            nx_vec = 8'($urandom_range(0, 255));
                            nx_hid = 16'($urandom_range(0, 65535));
                        end
                    endcase
                end else if (pick < reg_cut) begin
                    nx_cmd = CMD_REG;
                    if ($urandom_range(0, 19) == 0) begin
                        nx_vec = 8'($urandom_range(1, 255));
                    end
                    // odd handler ids are remembered so a later remove can clear them
                    if ($urandom_range(0, 24) == 0) begin
                        nx_hid = 16'($urandom_range(1, 65535));
                        spare_hids.push_back(nx_hid);
                    end
                end else if (pick < rem_cut) begin
                    nx_cmd = CMD_REM;
                    if (spare_hids.size() > 0 && $urandom_range(0, 3) == 0) begin
                        nx_hid = spare_hids.pop_front();
                    end
                end else begin
                    nx_cmd = CMD_LOOK;
                    if ($urandom_range(0, 9) == 0) begin
                        nx_vec = 8'($urandom_range(1, 255));
                    end
                end

                issue(nx_cmd, nx_vec, nx_hid, $urandom, $urandom,
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                beats_sent++;

                // bursts of back-to-back beats with idle gaps between them
                if (gaps_on) begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 15)) @(posedge clk);
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
        end

        // ---- drain ----
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // room for a stray late beat to show up
        repeat (TABLE_SLOTS + 4) @(posedge clk);

        if (errors == 0) begin
            $display("interrupt_vector_handler_table test passed");
        end else begin
            $display("interrupt_vector_handler_table test failed");
        end
        $finish;
    end

endmodule
